// ===== hdl/urc_pkg.sv =====
// ----------------------------------------------------------------------------
// urc_pkg: ultrasonic range controller package
// Transaction types, register map and reset values for the ranging block.
// ----------------------------------------------------------------------------
package urc_pkg;

   localparam int COUNTER_WIDTH_DEF = 20;

   localparam int TRIG_W   = 10;
   localparam int HOLD_W   = 20;
   localparam int MAXE_W   = 20;
   localparam int SPEED_W  = 15;
   localparam int DIST_W   = 34;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST  = TRIG_W'(10);
   localparam logic [HOLD_W-1:0]  HOLDOFF_TICKS_RST  = HOLD_W'(10000);
   localparam logic [MAXE_W-1:0]  MAX_ECHO_TICKS_RST = MAXE_W'(18000);
   localparam logic [SPEED_W-1:0] SOUND_SPEED_RST    = SPEED_W'(13512);

   localparam logic [DIST_W-1:0]  DIST_MAX = {DIST_W{1'b1}};

   typedef enum logic [1:0] {
      REG_TRIGGER_TICKS  = 2'd0,
      REG_HOLDOFF_TICKS  = 2'd1,
      REG_MAX_ECHO_TICKS = 2'd2,
      REG_SOUND_SPEED    = 2'd3
   } reg_idx_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_RISE = 4'b0100,
      PH_MEAS = 4'b1000
   } phase_type;

   typedef struct packed {
      logic start_request;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              done_res;
      logic              over_range;
      logic [DIST_W-1:0] distance_uinch;
   } rsp_type;

endpackage

// ===== hdl/ultrasonic_range_controller.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_controller: trigger/echo ranging controller
// Drives a sensor trigger pulse on request and times the echo pulse.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ transaction is one 1 us tick: the sampled echo pin level and a
//   measurement request. Every accepted tick yields exactly one rsp_
//   transaction carrying the trigger pin level for that tick, busy, done,
//   out of range and the distance in micro-inches.
//   A tick's result is loaded into the output register at the edge that
//   accepts the tick and is offered on rsp_ from the next cycle.
//   Throughput is one tick per cycle while req_stall is low; the tick
//   state and the distance multiply (echo width / 2 times sound speed) sit
//   between the state registers and the output register.
//   If the receiver stalls, the result is held and req_stall is raised only
//   while the output register is full and stalled; nothing is dropped.
//   Reset (synchronous) loads the register defaults, returns to idle with no
//   request pending and no holdoff, and empties the output register. The user
//   writes registers over the csr_ port (byte address 4 * index) only while no
//   transaction is in flight (not enforced); new values act at once.
// ----------------------------------------------------------------------------
module ultrasonic_range_controller
   import urc_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int CW   = COUNTER_WIDTH;
   localparam int PW   = CW + SPEED_W - 1;
   localparam logic [32:0] CNT_MAX = 33'((64'd1 << CW) - 64'd1);

   logic [TRIG_W-1:0]  trigger_ticks_ff;
   logic [HOLD_W-1:0]  holdoff_ticks_ff;
   logic [MAXE_W-1:0]  max_echo_ticks_ff;
   logic [SPEED_W-1:0] sound_speed_ff;

   phase_type          phase_ff, phase_in;
   logic               pending_ff, pending_in;
   logic [CW-1:0]      tick_count_ff, tick_count_in;
   logic [HOLD_W-1:0]  holdoff_left_ff, holdoff_left_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               csr_wr;
   logic [TRIG_W-1:0]  tlen;
   logic [CW-1:0]      tick_plus;
   logic [32:0]        cap_wide;
   logic [32:0]        cap_clip;
   logic [PW-1:0]      product;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff  <= TRIGGER_TICKS_RST;
         holdoff_ticks_ff  <= HOLDOFF_TICKS_RST;
         max_echo_ticks_ff <= MAX_ECHO_TICKS_RST;
         sound_speed_ff    <= SOUND_SPEED_RST;
      end else if (csr_wr) begin
         case (reg_idx_type'(csr_paddr[3:2]))
            REG_TRIGGER_TICKS:  trigger_ticks_ff  <= csr_pwdata[TRIG_W-1:0];
            REG_HOLDOFF_TICKS:  holdoff_ticks_ff  <= csr_pwdata[HOLD_W-1:0];
            REG_MAX_ECHO_TICKS: max_echo_ticks_ff <= csr_pwdata[MAXE_W-1:0];
            REG_SOUND_SPEED:    sound_speed_ff    <= csr_pwdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx_type'(csr_paddr[3:2]))
         REG_TRIGGER_TICKS:  csr_prdata = CSR_DW'(trigger_ticks_ff);
         REG_HOLDOFF_TICKS:  csr_prdata = CSR_DW'(holdoff_ticks_ff);
         REG_MAX_ECHO_TICKS: csr_prdata = CSR_DW'(max_echo_ticks_ff);
         REG_SOUND_SPEED:    csr_prdata = CSR_DW'(sound_speed_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Tick logic
   // ------------------------------------------------------------------
   assign tlen      = (trigger_ticks_ff == '0) ? TRIG_W'(1) : trigger_ticks_ff;
   assign tick_plus = tick_count_ff + CW'(1);
   assign cap_wide  = 33'(max_echo_ticks_ff) + 33'd1;
   // echo width stops at max + 1, or at the counter's all-ones value
   assign cap_clip  = (cap_wide > CNT_MAX) ? CNT_MAX : cap_wide;
   assign product   = PW'(tick_count_ff[CW-1:1]) * PW'(sound_speed_ff);

   always_comb begin
      phase_in        = phase_ff;
      pending_in      = pending_ff | req_data.start_request;
      tick_count_in   = tick_count_ff;
      holdoff_left_in = holdoff_left_ff;
      rsp_data_in     = '0;

      case (phase_ff)
         PH_TRIG: begin
            rsp_data_in.trigger_level = 1'b1;
            tick_count_in = tick_plus;
            if (33'(tick_plus) >= 33'(tlen)) begin
               phase_in = PH_RISE;
            end
         end
         PH_RISE: begin
            if (req_data.echo_level) begin
               tick_count_in = CW'(1);
               phase_in      = PH_MEAS;
            end
         end
         PH_MEAS: begin
            if (req_data.echo_level) begin
               if (33'(tick_count_ff) < cap_clip) begin
                  tick_count_in = tick_plus;
               end else begin
                  tick_count_in = CW'(cap_clip);
               end
            end else begin
               rsp_data_in.done_res = 1'b1;
               if (33'(tick_count_ff) > 33'(max_echo_ticks_ff)) begin
                  rsp_data_in.over_range = 1'b1;
               end else if (48'(product) > 48'(DIST_MAX)) begin
                  rsp_data_in.distance_uinch = DIST_MAX;
               end else begin
                  rsp_data_in.distance_uinch = DIST_W'(product);
               end
               phase_in        = PH_IDLE;
               holdoff_left_in = holdoff_ticks_ff;
            end
         end
         default: begin
            // idle: run down the holdoff before a pending request may start
            phase_in = PH_IDLE;
            if (holdoff_left_ff != '0) begin
               holdoff_left_in = holdoff_left_ff - HOLD_W'(1);
            end else if (pending_in) begin
               pending_in                = 1'b0;
               rsp_data_in.trigger_level = 1'b1;
               tick_count_in             = CW'(1);
               phase_in                  = (tlen <= TRIG_W'(1)) ? PH_RISE : PH_TRIG;
            end
         end
      endcase

      rsp_data_in.busy_res = pending_in | (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         pending_ff      <= 1'b0;
         tick_count_ff   <= '0;
         holdoff_left_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff        <= phase_in;
            pending_ff      <= pending_in;
            tick_count_ff   <= tick_count_in;
            holdoff_left_ff <= holdoff_left_in;
            rsp_valid_ff    <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_fire_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_holdoff_idle: assert property (@(posedge clock) disable iff (reset)
      (holdoff_left_ff != '0) |-> (phase_ff == PH_IDLE))
      else $error("holdoff running outside idle");

   a_meas_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MEAS) |-> (tick_count_ff != '0))
      else $error("echo width zero while measuring");

   a_done_no_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.done_res && rsp_data_ff.trigger_level))
      else $error("trigger high on completion tick");

   a_oor_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.over_range)
         |-> (rsp_data_ff.done_res && (rsp_data_ff.distance_uinch == '0)))
      else $error("out of range without done or with distance");
`endif

endmodule

// ===== sim/tb_ultrasonic_range_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_controller: tick-level testbench for the ranging block
// Streams echo/request ticks into the block under random source gaps and
// sink stalls, predicts every per-tick result (trigger, busy, done, out of
// range, distance) and compares each field. Register settings change
// between batches, including while a measurement is still in progress.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_controller;
   import urc_pkg::*;

   localparam int CW = COUNTER_WIDTH_DEF;
   localparam logic [63:0] CNT_MAX = (64'd1 << CW) - 64'd1;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   ultrasonic_range_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // register shadows
   logic [TRIG_W-1:0]  cfg_trig  = TRIGGER_TICKS_RST;
   logic [HOLD_W-1:0]  cfg_hold  = HOLDOFF_TICKS_RST;
   logic [MAXE_W-1:0]  cfg_max   = MAX_ECHO_TICKS_RST;
   logic [SPEED_W-1:0] cfg_speed = SOUND_SPEED_RST;

   // predicted controller state
   phase_type          ctl_phase   = PH_IDLE;
   logic               req_held    = 1'b0;
   logic [CW-1:0]      width_cnt   = '0;
   logic [HOLD_W-1:0]  holdoff_cnt = '0;

   req_type     stim_ticks[$];
   rsp_type     predicted_ticks[$];
   rsp_type     want;
   int unsigned ticks_queued = 0;
   int unsigned ticks_acc = 0;
   int unsigned results_seen = 0;
   int unsigned done_total = 0;
   int unsigned oor_total = 0;
   int unsigned csr_writes = 0;
   int unsigned mismatch_cnt = 0;
   int unsigned cycle_cnt = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   bit          no_idle = 1'b0;

   // advance the ranging state by one tick and return that tick's result
   function automatic rsp_type ranging_tick(req_type t);
      rsp_type     r;
      logic [63:0] cap;
      logic [63:0] prod;
      logic [TRIG_W-1:0] tlen;
      r = '0;
      tlen = (cfg_trig == 0) ? TRIG_W'(1) : cfg_trig;
      if (t.start_request) req_held = 1'b1;
      case (ctl_phase)
         PH_TRIG: begin
            r.trigger_level = 1'b1;
            width_cnt = width_cnt + CW'(1);
            if (width_cnt >= CW'(tlen)) ctl_phase = PH_RISE;
         end
         PH_RISE: begin
            if (t.echo_level) begin
               width_cnt = CW'(1);
               ctl_phase = PH_MEAS;
            end
         end
         PH_MEAS: begin
            if (t.echo_level) begin
               cap = 64'(cfg_max) + 64'd1;
               if (cap > CNT_MAX) cap = CNT_MAX;
               if (64'(width_cnt) < cap) width_cnt = width_cnt + CW'(1);
               else width_cnt = cap[CW-1:0];
            end else begin
               r.done_res = 1'b1;
               if (64'(width_cnt) > 64'(cfg_max)) begin
                  r.over_range = 1'b1;
               end else begin
                  prod = 64'(width_cnt >> 1) * 64'(cfg_speed);
                  if (prod > 64'(DIST_MAX)) prod = 64'(DIST_MAX);
                  r.distance_uinch = prod[DIST_W-1:0];
               end
               ctl_phase = PH_IDLE;
               holdoff_cnt = cfg_hold;
            end
         end
         default: begin
            ctl_phase = PH_IDLE;
            if (holdoff_cnt != 0) begin
               holdoff_cnt = holdoff_cnt - HOLD_W'(1);
            end else if (req_held) begin
               req_held = 1'b0;
               r.trigger_level = 1'b1;
               width_cnt = CW'(1);
               ctl_phase = (tlen <= TRIG_W'(1)) ? PH_RISE : PH_TRIG;
            end
         end
      endcase
      r.busy_res = req_held || (ctl_phase != PH_IDLE);
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   task automatic report_mismatch(string what);
      mismatch_cnt++;
      $display("mismatch at result %0d: %s", results_seen, what);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
   endtask

   // source side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_ticks.push_back(ranging_tick(req_data));
            if (predicted_ticks[$].done_res) done_total++;
            if (predicted_ticks[$].over_range) oor_total++;
            ticks_acc++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (stim_ticks.size() != 0) begin
               req_data <= stim_ticks.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // sink side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_ticks.size() == 0) begin
               report_mismatch("result with no tick outstanding");
            end else begin
               want = predicted_ticks.pop_front();
               check_field("trigger_level", 64'(rsp_data.trigger_level),
                           64'(want.trigger_level));
               check_field("busy_res", 64'(rsp_data.busy_res), 64'(want.busy_res));
               check_field("done_res", 64'(rsp_data.done_res), 64'(want.done_res));
               check_field("over_range", 64'(rsp_data.over_range),
                           64'(want.over_range));
               check_field("distance_uinch", 64'(rsp_data.distance_uinch),
                           64'(want.distance_uinch));
            end
            results_seen++;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d ticks accepted", cycle_cnt, ticks_acc);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_write(reg_idx_type idx, int unsigned val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= CSR_DW'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_TRIGGER_TICKS:  cfg_trig  = val[TRIG_W-1:0];
         REG_HOLDOFF_TICKS:  cfg_hold  = val[HOLD_W-1:0];
         REG_MAX_ECHO_TICKS: cfg_max   = val[MAXE_W-1:0];
         REG_SOUND_SPEED:    cfg_speed = val[SPEED_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic add_tick(bit rq, bit echo);
      req_type t;
      t.start_request = rq;
      t.echo_level = echo;
      stim_ticks.push_back(t);
      ticks_queued++;
   endtask

   task automatic add_run(bit rq, bit echo, int unsigned n);
      for (int unsigned i = 0; i < n; i++) add_tick(rq, echo);
   endtask

   // request, echo low long enough to get past holdoff and trigger, echo pulse
   task automatic queue_measurement(int unsigned wait_n, int unsigned width, bit noisy);
      add_tick(1'b1, noisy && ($urandom_range(0, 1) == 1));
      for (int unsigned i = 0; i < wait_n; i++)
         add_tick(noisy && ($urandom_range(0, 7) == 0),
                  noisy && (i < 3) && ($urandom_range(0, 1) == 1));
      for (int unsigned i = 0; i < width; i++)
         add_tick(noisy && ($urandom_range(0, 9) == 0), 1'b1);
      add_tick(1'b0, 1'b0);
   endtask

   // block is quiet once every queued tick has come back
   task automatic drain();
      while (ticks_acc != ticks_queued || predicted_ticks.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned r, w, wait_n, tlen, prev_hold, phase_no, rand_base, n_meas, settle;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero trigger length, request while busy, echo saturation
      csr_write(REG_TRIGGER_TICKS, 0);
      csr_write(REG_HOLDOFF_TICKS, 2);
      csr_write(REG_MAX_ECHO_TICKS, 3);
      csr_write(REG_SOUND_SPEED, 32767);
      add_tick(1'b0, 1'b1);
      add_tick(1'b1, 1'b1);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 1'b1, 5);
      add_tick(1'b0, 1'b0);
      add_run(1'b0, 1'b0, 3);
      add_run(1'b0, 1'b1, 2);
      add_tick(1'b0, 1'b0);
      add_tick(1'b0, 1'b1);
      drain();
      // zero maximum: even a one-tick echo is out of range
      csr_write(REG_MAX_ECHO_TICKS, 0);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 1'b0, 3);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b0);
      drain();

      rand_base = ticks_queued;
      phase_no = 0;
      prev_hold = 32'(cfg_hold);
      while ((ticks_queued - rand_base) < 420) begin
         phase_no++;
         no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 4);
         csr_write(REG_TRIGGER_TICKS, (phase_no == 1) ? 1000 :
                   (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 20));
         csr_write(REG_HOLDOFF_TICKS,
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
         r = $urandom_range(0, 7);
         csr_write(REG_MAX_ECHO_TICKS, (r == 0) ? 0 : (r == 1) ? 1 :
                   (r == 2) ? 1000000 : (r == 3) ? 20'hFFFFF : $urandom_range(2, 40));
         r = $urandom_range(0, 5);
         csr_write(REG_SOUND_SPEED, (r == 0) ? 1 : (r == 1) ? 20000 :
                   (r == 2) ? 32767 : $urandom_range(1, 32767));
         tlen = (cfg_trig == 0) ? 1 : 32'(cfg_trig);
         n_meas = (phase_no == 1) ? 0 : $urandom_range(2, 5);
         for (int unsigned m = 0; m < n_meas; m++) begin
            if ($urandom_range(0, 4) == 0)
               for (int unsigned k = $urandom_range(4, 16); k != 0; k--)
                  add_tick($urandom_range(0, 15) == 0, $urandom_range(0, 1) == 1);
            r = $urandom_range(0, 3);
            if (r == 0) w = $urandom_range(1, 4);
            else if (r == 1 && cfg_max < 40) w = 32'(cfg_max) + $urandom_range(0, 2);
            else w = $urandom_range(1, 45);
            if (w == 0) w = 1;
            // holdoff left from the previous batch may be the longer one
            wait_n = ((m == 0 && prev_hold > cfg_hold) ? prev_hold : 32'(cfg_hold))
                     + tlen + $urandom_range(0, 4);
            queue_measurement(wait_n, w, $urandom_range(0, 3) == 0);
         end
         if (phase_no == 1) begin
            // longest trigger pulse, cut short by the next batch's trigger write
            add_tick(1'b1, 1'b0);
            add_run(1'b0, 1'b0, prev_hold + 20);
         end else if ($urandom_range(0, 3) == 0) begin
            // sometimes leave a measurement running across the next register writes
            add_tick(1'b1, 1'b0);
            add_run(1'b0, 1'b0, $urandom_range(0, 3));
         end
         prev_hold = 32'(cfg_hold);
         drain();
      end

      // longest holdoff: after this measurement nothing may start again
      no_idle = 1'b0;
      csr_write(REG_HOLDOFF_TICKS, 1000000);
      tlen = (cfg_trig == 0) ? 1 : 32'(cfg_trig);
      queue_measurement(prev_hold + tlen + 3, 2, 1'b0);
      for (int unsigned k = 0; k < 120; k++)
         add_tick($urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);

      while (ticks_acc != ticks_queued) @(negedge clock);
      settle = 0;
      while (predicted_ticks.size() != 0 && settle < 200) begin
         @(negedge clock);
         settle++;
      end
      repeat (10) @(negedge clock);
      if (predicted_ticks.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", predicted_ticks.size()));

      $display("summary: %0d ticks, %0d register writes over %0d batches",
               ticks_acc, csr_writes, phase_no + 3);
      $display("summary: %0d measurements done, %0d out of range, %0d mismatches",
               done_total, oor_total, mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== ultrasonic_range_controller.f =====
hdl/urc_pkg.sv
hdl/ultrasonic_range_controller.sv
sim/tb_ultrasonic_range_controller.sv
